@@ rtl/core/tvi_pkg.sv @@
package tvi_pkg;

  localparam int unsigned CFG_AW   = 1;
  localparam int unsigned CFG_DW   = 23;
  localparam int unsigned LOG_FRAC = 20;

  localparam logic [CFG_AW-1:0] REG_CURVE_MIN = 1'd0;
  localparam logic [CFG_AW-1:0] REG_CURVE_MAX = 1'd1;

  localparam logic [22:0] CURVE_MIN_RST = 23'd0;
  localparam logic [22:0] CURVE_MAX_RST = 23'd1085478;

  // piece thresholds on raw base luminance
  localparam logic [23:0] TH_LOW  = 24'd223;
  localparam logic [23:0] TH_MID  = 24'd65536;
  localparam logic [23:0] TH_HIGH = 24'd474766;

  localparam logic [24:0] LOG2_LOW  = 25'd8178636;
  localparam logic [24:0] LOG2_HIGH = 25'd19772857;
  localparam logic [22:0] SEG2_BASE = 23'd160452;
  localparam logic [19:0] SEG2_K    = 20'd112804;
  localparam logic [22:0] SEG3_BASE = 23'd1085473;
  localparam logic [22:0] SEG4_BASE = 23'd2101694;
  localparam logic [19:0] SEG4_K    = 20'd817016;

  // reciprocals: x/14 for x < 2^22, x/4027 for x < 2^32
  localparam logic [22:0] RECIP14   = 23'd4793491;
  localparam int unsigned SH14      = 26;
  localparam logic [32:0] RECIP4027 = 33'd4368558740;
  localparam int unsigned SH4027    = 44;

  typedef enum logic [1:0] {
    SEG_LIN_LOW,
    SEG_LOG_LOW,
    SEG_LIN_HIGH,
    SEG_LOG_HIGH
  } seg_t;

  typedef struct packed {
    logic [23:0] base_lum;
    logic [15:0] detail_ratio;
    logic [15:0] gray_lum;
    logic [15:0] chan_b;
    logic [15:0] chan_g;
    logic [15:0] chan_r;
  } in_t;

  typedef struct packed {
    logic [15:0] out_b;
    logic [15:0] out_g;
    logic [15:0] out_r;
  } out_t;

  // log2 of cell midpoint 1 + (2k+1)/2^(bits+1), Q.20, by repeated squaring
  function automatic logic [LOG_FRAC-1:0] log_entry(int unsigned k, int unsigned bits);
    logic [63:0]          m;
    logic [LOG_FRAC-1:0]  acc;
    m   = (64'd1 << 30) + (64'(2 * k + 1) << (29 - bits));
    acc = '0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m   = (m * m) >> 30;
      acc = acc << 1;
      if (m >= (64'd2 << 30)) begin
        m      = m >> 1;
        acc[0] = 1'b1;
      end
    end
    return acc;
  endfunction

endpackage

@@ rtl/core/tvi_tone_curve_pixel_map.sv @@
// Channel  Direction  Handshake            Payload
// in       input      start / busy         in_data  (tvi_pkg::in_t)
// out      output     out_valid strobe     out_data (tvi_pkg::out_t)
// cfg      input      cfg_we               cfg_addr, cfg_wdata
//
// One word enters per clock; busy is always low. Each word passes through
// 6 curve/product stages, then 17 stages of the restoring divider (an entry
// stage, then one quotient bit per stage).
// Reset (rst_n low, synchronous) clears the valid line and loads the curve
// registers with their defaults. The receiver cannot stall, so nothing holds.
module tvi_tone_curve_pixel_map #(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  tvi_pkg::in_t               in_data,
  output logic                       out_valid,
  output tvi_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [tvi_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tvi_pkg::CFG_DW-1:0] cfg_wdata
);
  import tvi_pkg::*;

  localparam int unsigned TBL_SIZE = 1 << LOG_TABLE_BITS;
  localparam int unsigned LAT      = 23;

  // log2 mantissa table, constant
  logic [LOG_FRAC-1:0] log_tbl [TBL_SIZE];
  for (genvar g = 0; g < TBL_SIZE; g++) begin : g_tbl
    assign log_tbl[g] = log_entry(g, LOG_TABLE_BITS);
  end

  // configuration
  logic [22:0] cmin_r, cmax_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmin_r <= CURVE_MIN_RST;
      cmax_r <= CURVE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CURVE_MIN: cmin_r <= cfg_wdata;
        REG_CURVE_MAX: cmax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid line
  logic vld_r [LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // stage 1: piece select, exponent, table index, linear dividends
  logic [23:0]               r;
  logic [4:0]                exp_c;
  logic [23+LOG_TABLE_BITS:0] rsh;
  seg_t                      seg_c;
  assign r = in_data.base_lum;

  always_comb begin
    exp_c = '0;
    for (int i = 0; i < 24; i++) begin
      if (r[i]) exp_c = 5'(i);
    end
  end

  assign rsh = {r, {LOG_TABLE_BITS{1'b0}}} >> exp_c;

  always_comb begin
    if (r < TH_LOW)       seg_c = SEG_LIN_LOW;
    else if (r < TH_MID)  seg_c = SEG_LOG_LOW;
    else if (r < TH_HIGH) seg_c = SEG_LIN_HIGH;
    else                  seg_c = SEG_LOG_HIGH;
  end

  seg_t                      seg1_r;
  logic [4:0]                exp1_r;
  logic [LOG_TABLE_BITS-1:0] k1_r;
  logic [21:0]               x1_r;
  logic [31:0]               x3_r;
  in_t                       pix1_r;
  always_ff @(posedge clk) begin
    seg1_r <= seg_c;
    exp1_r <= exp_c;
    k1_r   <= rsh[LOG_TABLE_BITS-1:0];
    x1_r   <= 22'(32'(r) * 32'd10000 + 32'd7);
    x3_r   <= (32'(r) - 32'd65536) * 32'd10000 + 32'd2013;
    pix1_r <= in_data;
  end

  // stage 2: log2, offset, reciprocal products
  logic [24:0] log2_c, off_c;
  assign log2_c = {exp1_r, {LOG_FRAC{1'b0}}} + 25'(log_tbl[k1_r]);
  assign off_c  = (seg1_r == SEG_LOG_LOW) ? LOG2_LOW : LOG2_HIGH;

  seg_t        seg2_r;
  logic [24:0] d2_r;
  logic [44:0] p1_r;
  logic [48:0] plo_r;
  logic [47:0] phi_r;
  in_t         pix2_r;
  always_ff @(posedge clk) begin
    seg2_r <= seg1_r;
    d2_r   <= (log2_c > off_c) ? 25'(log2_c - off_c) : '0;
    p1_r   <= 45'(x1_r * RECIP14);
    plo_r  <= 49'(x3_r * RECIP4027[16:0]);
    phi_r  <= 48'(x3_r * RECIP4027[32:17]);
    pix2_r <= pix1_r;
  end

  // stage 3: curve value
  logic [19:0] kq_c;
  logic [22:0] lbase_c, cv_c;
  logic [45:0] lprod_c;
  logic [65:0] p3_c;
  assign kq_c    = (seg2_r == SEG_LOG_LOW) ? SEG2_K : SEG4_K;
  assign lbase_c = (seg2_r == SEG_LOG_LOW) ? SEG2_BASE : SEG4_BASE;
  assign lprod_c = 46'(d2_r * kq_c) + 46'(1 << 19);
  assign p3_c    = 66'(plo_r) + (66'(phi_r) << 17);

  always_comb begin
    case (seg2_r)
      SEG_LIN_LOW:  cv_c = 23'(p1_r >> SH14);
      SEG_LIN_HIGH: cv_c = SEG3_BASE + 23'(p3_c >> SH4027);
      default:      cv_c = lbase_c + 23'(lprod_c >> LOG_FRAC);
    endcase
  end

  logic [22:0] cv_r;
  in_t         pix3_r;
  always_ff @(posedge clk) begin
    cv_r   <= cv_c;
    pix3_r <= pix2_r;
  end

  // stage 4: numerator, span, saturation flag
  logic [22:0] num4_r, span4_r;
  logic        sat4_r;
  in_t         pix4_r;
  always_ff @(posedge clk) begin
    num4_r  <= (cv_r > cmin_r) ? cv_r - cmin_r : '0;
    span4_r <= cmax_r - cmin_r;
    sat4_r  <= (pix3_r.gray_lum == '0) || (cmax_r <= cmin_r);
    pix4_r  <= pix3_r;
  end

  // stage 5: channel * num, span * gray
  logic [38:0] ab5_r, ag5_r, ar5_r, den5_r;
  logic [15:0] det5_r;
  logic        sat5_r;
  always_ff @(posedge clk) begin
    ab5_r  <= 39'(pix4_r.chan_b * num4_r);
    ag5_r  <= 39'(pix4_r.chan_g * num4_r);
    ar5_r  <= 39'(pix4_r.chan_r * num4_r);
    den5_r <= 39'(span4_r * pix4_r.gray_lum);
    det5_r <= pix4_r.detail_ratio;
    sat5_r <= sat4_r;
  end

  // stage 6: times detail ratio
  logic [54:0] nb6_r, ng6_r, nr6_r;
  logic [38:0] den6_r;
  logic        sat6_r;
  always_ff @(posedge clk) begin
    nb6_r  <= 55'(ab5_r * det5_r);
    ng6_r  <= 55'(ag5_r * det5_r);
    nr6_r  <= 55'(ar5_r * det5_r);
    den6_r <= den5_r;
    sat6_r <= sat5_r;
  end

  // stages 7..23: dividers
  tvi_div_lane u_div_b (.clk(clk), .num(nb6_r), .den(den6_r), .sat(sat6_r),
                        .quo(out_data.out_b));
  tvi_div_lane u_div_g (.clk(clk), .num(ng6_r), .den(den6_r), .sat(sat6_r),
                        .quo(out_data.out_g));
  tvi_div_lane u_div_r (.clk(clk), .num(nr6_r), .den(den6_r), .sat(sat6_r),
                        .quo(out_data.out_r));

  assign out_valid = vld_r[LAT-1];

  // a result strobe always traces back to an accepted word
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching input word");

  // third piece never falls below its base
  a_lin_high: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && seg2_r == SEG_LIN_HIGH) |=> (cv_r >= SEG3_BASE))
    else $error("linear high piece below base");

endmodule

@@ rtl/core/tvi_div_lane.sv @@
module tvi_div_lane (
  input  logic        clk,
  input  logic [54:0] num,
  input  logic [38:0] den,
  input  logic        sat,
  output logic [15:0] quo
);
  import tvi_pkg::*;

  localparam int unsigned QB = 16;

  logic [38:0]   rem_r [QB];
  logic [38:0]   den_r [QB];
  logic [QB-1:0] q_r   [QB+1];
  logic          sat_r [QB+1];
  logic [QB-1:0] lo_r  [QB];

  // entry: saturate when quotient would not fit 16 bits
  always_ff @(posedge clk) begin
    sat_r[0] <= sat || (num[54:16] >= den);
    rem_r[0] <= num[54:16];
    lo_r[0]  <= num[15:0];
    den_r[0] <= den;
    q_r[0]   <= '0;
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [39:0] trial;
    logic        ge;
    assign trial = {rem_r[s], lo_r[s][QB-1]};
    assign ge    = trial >= {1'b0, den_r[s]};
    always_ff @(posedge clk) begin
      q_r[s+1]   <= {q_r[s][QB-2:0], ge};
      sat_r[s+1] <= sat_r[s];
    end
    // last step keeps only the quotient
    if (s < QB - 1) begin : g_lo
      always_ff @(posedge clk) begin
        rem_r[s+1] <= ge ? 39'(trial - {1'b0, den_r[s]}) : trial[38:0];
        den_r[s+1] <= den_r[s];
        lo_r[s+1]  <= lo_r[s] << 1;
      end
    end
  end

  assign quo = sat_r[QB] ? '1 : q_r[QB];

endmodule
